@@ rtl/core/slb_pkg.sv @@
// Shared types and constants for the seam linear blend pipeline.
package slb_pkg;

  localparam int unsigned COL_W  = 13;
  localparam int unsigned WID_W  = 14;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NCH    = 3;
  localparam int unsigned NUM_W  = WID_W + CH_W;
  localparam int unsigned QBITS  = CH_W;
  localparam int unsigned CIDX_W = 2;

  // Register indexes of the configuration channel.
  localparam logic [CIDX_W-1:0] CFG_OVERLAP_START = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;

  typedef logic [NCH-1:0][CH_W-1:0] pixel_t;

  // Accepted input request.
  typedef struct packed {
    logic [COL_W-1:0] column;
    pixel_t           left_px;
    pixel_t           warp_px;
  } pix_req_t;

  // Weights chosen by the select stage; bypass cases use divisor one.
  typedef struct packed {
    pixel_t           left_px;
    pixel_t           warp_px;
    logic [WID_W-1:0] w;
    logic [WID_W-1:0] k;
  } mix_t;

  // Partial division state handed from cell to cell.
  typedef struct packed {
    logic [NCH-1:0][NUM_W-1:0] rem;
    logic [NCH-1:0][QBITS-1:0] quo;
    logic [NUM_W-1:0]          dsh;
  } work_t;

endpackage

@@ rtl/core/slb_if.sv @@
// Stream and configuration channel interfaces of the seam linear blend unit.
interface slb_pix_if;
  logic                        valid;
  logic                        ready;
  logic [slb_pkg::COL_W-1:0]   column;
  logic [slb_pkg::CH_W-1:0]    left_ch0;
  logic [slb_pkg::CH_W-1:0]    left_ch1;
  logic [slb_pkg::CH_W-1:0]    left_ch2;
  logic [slb_pkg::CH_W-1:0]    warped_ch0;
  logic [slb_pkg::CH_W-1:0]    warped_ch1;
  logic [slb_pkg::CH_W-1:0]    warped_ch2;

  modport source (output valid, column, left_ch0, left_ch1, left_ch2,
                  warped_ch0, warped_ch1, warped_ch2, input ready);
  modport sink   (input valid, column, left_ch0, left_ch1, left_ch2,
                  warped_ch0, warped_ch1, warped_ch2, output ready);
endinterface

interface slb_res_if;
  logic                     valid;
  logic                     ready;
  logic [slb_pkg::CH_W-1:0] out_ch0;
  logic [slb_pkg::CH_W-1:0] out_ch1;
  logic [slb_pkg::CH_W-1:0] out_ch2;

  modport source (output valid, out_ch0, out_ch1, out_ch2, input ready);
  modport sink   (input valid, out_ch0, out_ch1, out_ch2, output ready);
endinterface

interface slb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [slb_pkg::CIDX_W-1:0] index;
  logic [slb_pkg::WID_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/seam_linear_blend_unit.sv @@
// Top level of the seam linear blend unit: config registers and cell pipeline.
//
// Usage: pixel requests arrive on pix_i (column, reference and warped RGB),
// blended pixels leave on res_o, and cfg_i writes overlap_start (index 0) and
// image_width (index 1); cfg_i is always ready and should be written while no
// pixel is in flight.
// Pipeline: a result is presented after its request has passed ten registers:
// one region-select stage, one weighted-sum stage and eight division cells,
// one cell per quotient bit.
// Throughput: one pixel per cycle while res_o is ready, set by the cell chain,
// in which each cell passes its partial remainders to the next cell.
// Reset: all stages empty, overlap_start 0, image_width MAX_WIDTH (14 bits).
// Stall: when res_o is not ready the last cell holds its result; earlier stages
// keep filling bubbles, and pix_i.ready drops only once every stage is full.
module seam_linear_blend_unit #(
  parameter int unsigned MAX_WIDTH = 8192
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  slb_pix_if.sink  pix_i,
  slb_res_if.source res_o,
  slb_cfg_if.sink  cfg_i
);

  localparam int unsigned NCELL = slb_pkg::QBITS;

  logic [slb_pkg::COL_W-1:0] overlap_start_q;
  logic [slb_pkg::WID_W-1:0] image_width_q;

  slb_pkg::pix_req_t pix_req;
  slb_pkg::mix_t     mix;
  logic              mix_valid, mix_ready;

  logic           [NCELL:0] cell_valid;
  logic           [NCELL:0] cell_ready;
  slb_pkg::work_t           cell_work [NCELL+1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlap_start_q <= '0;
      image_width_q   <= slb_pkg::WID_W'(MAX_WIDTH);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        slb_pkg::CFG_OVERLAP_START: overlap_start_q <= cfg_i.data[slb_pkg::COL_W-1:0];
        slb_pkg::CFG_IMAGE_WIDTH:   image_width_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign pix_req.column     = pix_i.column;
  assign pix_req.left_px[0] = pix_i.left_ch0;
  assign pix_req.left_px[1] = pix_i.left_ch1;
  assign pix_req.left_px[2] = pix_i.left_ch2;
  assign pix_req.warp_px[0] = pix_i.warped_ch0;
  assign pix_req.warp_px[1] = pix_i.warped_ch1;
  assign pix_req.warp_px[2] = pix_i.warped_ch2;

  slb_select u_select (
    .clk_i,
    .rst_ni,
    .overlap_start_i (overlap_start_q),
    .image_width_i   (image_width_q),
    .in_valid_i      (pix_i.valid),
    .in_ready_o      (pix_i.ready),
    .in_req_i        (pix_req),
    .out_valid_o     (mix_valid),
    .out_ready_i     (mix_ready),
    .out_mix_o       (mix)
  );

  slb_mac u_mac (
    .clk_i,
    .rst_ni,
    .in_valid_i  (mix_valid),
    .in_ready_o  (mix_ready),
    .in_mix_i    (mix),
    .out_valid_o (cell_valid[0]),
    .out_ready_i (cell_ready[0]),
    .out_work_o  (cell_work[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    slb_div_cell u_cell (
      .clk_i,
      .rst_ni,
      .in_valid_i  (cell_valid[i]),
      .in_ready_o  (cell_ready[i]),
      .in_work_i   (cell_work[i]),
      .out_valid_o (cell_valid[i+1]),
      .out_ready_i (cell_ready[i+1]),
      .out_work_o  (cell_work[i+1])
    );
  end

  assign res_o.valid       = cell_valid[NCELL];
  assign cell_ready[NCELL] = res_o.ready;
  assign res_o.out_ch0     = cell_work[NCELL].quo[0];
  assign res_o.out_ch1     = cell_work[NCELL].quo[1];
  assign res_o.out_ch2     = cell_work[NCELL].quo[2];

endmodule

@@ rtl/core/slb_select.sv @@
// Region decode: picks blend weights and divisor for one pixel request.
module slb_select (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [slb_pkg::COL_W-1:0]  overlap_start_i,
  input  logic [slb_pkg::WID_W-1:0]  image_width_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  slb_pkg::pix_req_t          in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output slb_pkg::mix_t              out_mix_o
);

  logic              valid_q;
  slb_pkg::mix_t     mix_q, mix_d;
  logic [slb_pkg::WID_W-1:0] col_ext, start_ext;
  logic              warp_zero;

  assign col_ext   = {1'b0, in_req_i.column};
  assign start_ext = {1'b0, overlap_start_i};
  assign warp_zero = (in_req_i.warp_px == '0);

  always_comb begin
    mix_d.left_px = in_req_i.left_px;
    mix_d.warp_px = in_req_i.warp_px;
    if (col_ext >= image_width_i) begin
      // take the warped pixel: divisor one, full weight on warp
      mix_d.w = slb_pkg::WID_W'(1);
      mix_d.k = slb_pkg::WID_W'(1);
    end else if (in_req_i.column < overlap_start_i || warp_zero) begin
      mix_d.w = slb_pkg::WID_W'(1);
      mix_d.k = '0;
    end else begin
      mix_d.w = image_width_i - start_ext;
      mix_d.k = col_ext - start_ext;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_mix_o   = mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mix_q <= mix_d;
    end
  end

endmodule

@@ rtl/core/slb_mac.sv @@
// Weighted sum stage: forms the dividend of each channel and seeds the divider.
module slb_mac (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  slb_pkg::mix_t  in_mix_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output slb_pkg::work_t out_work_o
);

  logic                       valid_q;
  slb_pkg::work_t             work_q, work_d;
  logic [slb_pkg::WID_W-1:0]  wmk;

  assign wmk = in_mix_i.w - in_mix_i.k;

  always_comb begin
    for (int c = 0; c < slb_pkg::NCH; c++) begin
      work_d.rem[c] = slb_pkg::NUM_W'(in_mix_i.left_px[c]) * slb_pkg::NUM_W'(wmk)
                    + slb_pkg::NUM_W'(in_mix_i.warp_px[c]) * slb_pkg::NUM_W'(in_mix_i.k);
    end
    work_d.quo = '0;
    // align divisor with the top quotient bit
    work_d.dsh = {1'b0, in_mix_i.w, {(slb_pkg::QBITS-1){1'b0}}};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

@@ rtl/core/slb_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit for all channels.
module slb_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  slb_pkg::work_t in_work_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output slb_pkg::work_t out_work_o
);

  logic           valid_q;
  slb_pkg::work_t work_q, work_d;

  always_comb begin
    for (int c = 0; c < slb_pkg::NCH; c++) begin
      if (in_work_i.rem[c] >= in_work_i.dsh) begin
        work_d.rem[c] = in_work_i.rem[c] - in_work_i.dsh;
        work_d.quo[c] = {in_work_i.quo[c][slb_pkg::QBITS-2:0], 1'b1};
      end else begin
        work_d.rem[c] = in_work_i.rem[c];
        work_d.quo[c] = {in_work_i.quo[c][slb_pkg::QBITS-2:0], 1'b0};
      end
    end
    // hand the next lower divisor weight to the neighbor
    work_d.dsh = in_work_i.dsh >> 1;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

  // remainder stays below the divisor weight just tested (its low bit may be shifted out)
  a_rem0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, work_q.rem[0]} < {work_q.dsh, 1'b1}))
    else $error("channel 0 remainder out of range");
  a_rem1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, work_q.rem[1]} < {work_q.dsh, 1'b1}))
    else $error("channel 1 remainder out of range");
  a_rem2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, work_q.rem[2]} < {work_q.dsh, 1'b1}))
    else $error("channel 2 remainder out of range");

endmodule

@@ verif/tb_seam_linear_blend_unit.sv @@
// Testbench for seam_linear_blend_unit: random pixel streams checked against a blend predictor.
module tb_seam_linear_blend_unit;

  logic clk_i;
  logic rst_ni;

  slb_pix_if pix_if ();
  slb_res_if res_if ();
  slb_cfg_if cfg_if ();

  seam_linear_blend_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  slb_pkg::pix_req_t         pixel_req_q[$];
  slb_pkg::pixel_t           blend_expect_q[$];
  logic [slb_pkg::COL_W-1:0] cur_start;
  logic [slb_pkg::WID_W-1:0] cur_width;
  logic                      pix_taken;
  bit                        quiet;
  int unsigned               hold_arm;
  int unsigned               hold_seen;
  int unsigned               hold_left;
  int unsigned               err_cnt;

  always #2 clk_i = ~clk_i;

  // Expected blended pixel for one request under the given register values.
  function automatic slb_pkg::pixel_t blend_pixel(input slb_pkg::pix_req_t req,
                                                  input logic [slb_pkg::COL_W-1:0] start,
                                                  input logic [slb_pkg::WID_W-1:0] width);
    slb_pkg::pixel_t px;
    int unsigned     w;
    int unsigned     k;
    int unsigned     num;
    if ({1'b0, req.column} >= width) begin
      px = req.warp_px;
    end else if (req.column < start) begin
      px = req.left_px;
    end else if (req.warp_px == '0) begin
      px = req.left_px;
    end else begin
      w = int'(width) - int'(start);
      k = int'(req.column) - int'(start);
      for (int c = 0; c < slb_pkg::NCH; c++) begin
        num = int'(req.left_px[c]) * (w - k) + int'(req.warp_px[c]) * k;
        px[c] = slb_pkg::CH_W'(num / w);
      end
    end
    return px;
  endfunction

  function automatic slb_pkg::pixel_t rand_px();
    slb_pkg::pixel_t px;
    for (int c = 0; c < slb_pkg::NCH; c++) px[c] = slb_pkg::CH_W'($urandom_range(255));
    return px;
  endfunction

  function automatic void push_pixel(input int unsigned col, input slb_pkg::pixel_t left_px,
                                     input slb_pkg::pixel_t warp_px);
    slb_pkg::pix_req_t req;
    req.column  = slb_pkg::COL_W'(col);
    req.left_px = left_px;
    req.warp_px = warp_px;
    pixel_req_q.insert(pixel_req_q.size(), req);
  endfunction

  // Random pixels, mostly in the current overlap span or within three columns of it.
  task automatic queue_random(input int unsigned n);
    int              lo;
    int              hi;
    int unsigned     col;
    int unsigned     sel;
    slb_pkg::pixel_t warp_px;
    lo = ((int'(cur_start) < int'(cur_width)) ? int'(cur_start) : int'(cur_width)) - 3;
    hi = ((int'(cur_start) > int'(cur_width)) ? int'(cur_start) : int'(cur_width)) + 3;
    if (lo < 0) lo = 0;
    if (hi > 8191) hi = 8191;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) col = $urandom_range(8191);
      else col = $urandom_range(hi, lo);
      sel = $urandom_range(99);
      warp_px = rand_px();
      if (sel < 12) begin
        warp_px = '0;
      end else if (sel < 18) begin
        warp_px = '0;
        warp_px[$urandom_range(slb_pkg::NCH-1)] = slb_pkg::CH_W'($urandom_range(255, 1));
      end
      push_pixel(col, rand_px(), warp_px);
    end
  endtask

  task automatic write_reg(input logic [slb_pkg::CIDX_W-1:0] idx,
                           input logic [slb_pkg::WID_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold until every request is in and every result is out, then let the pipe drain.
  task automatic drain();
    while (pixel_req_q.size() != 0 || pix_if.valid || blend_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (14) @(posedge clk_i);
  endtask

  // Request driver.
  always @(negedge clk_i) begin
    slb_pkg::pix_req_t req;
    if (!pix_if.valid || pix_taken) begin
      if (pixel_req_q.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
        req = pixel_req_q.pop_front();
        pix_if.column     <= req.column;
        pix_if.left_ch0   <= req.left_px[0];
        pix_if.left_ch1   <= req.left_px[1];
        pix_if.left_ch2   <= req.left_px[2];
        pix_if.warped_ch0 <= req.warp_px[0];
        pix_if.warped_ch1 <= req.warp_px[1];
        pix_if.warped_ch2 <= req.warp_px[2];
        pix_if.valid      <= 1'b1;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random back-pressure and one long hold-off when armed.
  always @(negedge clk_i) begin
    if (hold_arm != hold_seen) begin
      hold_seen = hold_arm;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  // Monitor: track registers, predict accepted requests, check results.
  always @(posedge clk_i) begin
    slb_pkg::pix_req_t req;
    slb_pkg::pixel_t   want;
    slb_pkg::pixel_t   got;
    pix_taken <= pix_if.valid && pix_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          slb_pkg::CFG_OVERLAP_START: cur_start = cfg_if.data[slb_pkg::COL_W-1:0];
          slb_pkg::CFG_IMAGE_WIDTH:   cur_width = cfg_if.data;
          default: ;
        endcase
      end
      if (pix_if.valid && pix_if.ready) begin
        req.column     = pix_if.column;
        req.left_px[0] = pix_if.left_ch0;
        req.left_px[1] = pix_if.left_ch1;
        req.left_px[2] = pix_if.left_ch2;
        req.warp_px[0] = pix_if.warped_ch0;
        req.warp_px[1] = pix_if.warped_ch1;
        req.warp_px[2] = pix_if.warped_ch2;
        blend_expect_q.insert(blend_expect_q.size(), blend_pixel(req, cur_start, cur_width));
      end
      if (res_if.valid && res_if.ready) begin
        got[0] = res_if.out_ch0;
        got[1] = res_if.out_ch1;
        got[2] = res_if.out_ch2;
        if (blend_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          err_cnt++;
        end else begin
          want = blend_expect_q.pop_front();
          for (int c = 0; c < slb_pkg::NCH; c++) begin
            if (got[c] !== want[c]) begin
              $display("%0t: out_ch%0d mismatch, expected %h, actual %h",
                       $time, c, want[c], got[c]);
              err_cnt++;
            end
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [slb_pkg::WID_W-1:0] start_tab[9];
    logic [slb_pkg::WID_W-1:0] width_tab[9];
    start_tab = '{14'd100, 14'd0, 14'd8191, 14'd5000, 14'd0, 14'd0, 14'h3FFF, 14'd4000, 14'd37};
    width_tab = '{14'd200, 14'd1, 14'd8192, 14'd3000, 14'd0, 14'd16383, 14'd16383, 14'd4003,
                  14'd8192};
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.column     = '0;
    pix_if.left_ch0   = '0;
    pix_if.left_ch1   = '0;
    pix_if.left_ch2   = '0;
    pix_if.warped_ch0 = '0;
    pix_if.warped_ch1 = '0;
    pix_if.warped_ch2 = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = slb_pkg::CFG_OVERLAP_START;
    cfg_if.data  = '0;
    cur_start = '0;
    cur_width = slb_pkg::WID_W'(8192);
    pix_taken = 1'b0;
    quiet     = 1'b0;
    hold_arm  = 0;
    hold_seen = 0;
    hold_left = 0;
    err_cnt   = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset setting: whole row is overlap.
    push_pixel(0, rand_px(), rand_px());
    push_pixel(8191, rand_px(), rand_px());
    push_pixel(4096, rand_px(), '0);
    push_pixel(8191, '1, '1);
    push_pixel(8191, '0, '1);
    push_pixel(1, '1, '1);
    push_pixel(0, '0, '0);
    push_pixel(5000, '1, {8'd0, 8'd0, 8'd1});
    drain();

    // Narrow overlap: edges, zero warp inside and outside.
    write_reg(slb_pkg::CFG_OVERLAP_START, 14'd100);
    write_reg(slb_pkg::CFG_IMAGE_WIDTH, 14'd200);
    push_pixel(99, rand_px(), rand_px());
    push_pixel(100, '1, '1);
    push_pixel(101, '1, '0);
    push_pixel(150, rand_px(), '0);
    push_pixel(150, '1, {8'd1, 8'd0, 8'd0});
    push_pixel(199, '0, '1);
    push_pixel(199, '1, '1);
    push_pixel(200, rand_px(), rand_px());
    push_pixel(250, rand_px(), '0);
    push_pixel(0, rand_px(), rand_px());
    push_pixel(8191, rand_px(), rand_px());
    drain();

    for (int p = 0; p < 9; p++) begin
      write_reg(slb_pkg::CFG_OVERLAP_START, start_tab[p]);
      write_reg(slb_pkg::CFG_IMAGE_WIDTH, width_tab[p]);
      @(posedge clk_i);
      quiet = (p == 2);
      if (p == 5) begin
        queue_random(120);
        // Starve the output so the pipe fills and stalls its input.
        hold_arm++;
      end else begin
        queue_random(48);
      end
      drain();
    end
    quiet = 1'b0;

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/slb_pkg.sv
rtl/core/slb_if.sv
rtl/core/slb_select.sv
rtl/core/slb_mac.sv
rtl/core/slb_div_cell.sv
rtl/core/seam_linear_blend_unit.sv
verif/tb_seam_linear_blend_unit.sv
